// File: hw/rtl/etp_pkg.sv
// ----------------------------------------------------------------------------
// etp_pkg
// Phase codes, byte constants and byte class helpers for the entity-tag
// parser.
// ----------------------------------------------------------------------------
package etp_pkg;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_STAR,
        PH_WPRE,
        PH_WSP,
        PH_INQ,
        PH_ESC,
        PH_CLOSED,
        PH_ERR
    } phase_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_W_UP   = 8'h57;
    localparam logic [7:0] CH_W_LO   = 8'h77;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
    endfunction

endpackage

// File: hw/rtl/entity_tag_parser.sv
// ----------------------------------------------------------------------------
// entity_tag_parser
// Streaming check of an HTTP entity-tag header value, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries data_byte and last, one byte of
//   the header value per word; last marks the final byte of a value.
//   Output channel (out_valid/out_ready) carries one result word per value:
//   valid_res, weak_res, wildcard_res, tag_start and tag_length.
//   A byte is taken into an input register; from there the phase update
//   writes the parser state, and a final byte loads the result register.
//   The result is registered behind the input register. Throughput: one
//   byte per cycle while no final byte waits, with a combinational phase
//   update between the input register and the parser state.
//   When the receiver stalls, non-final bytes keep flowing; a final byte waits
//   in the input register until the result register is free, and in_ready
//   drops only while it waits.
//   Reset clears the parser state to the leading-whitespace phase with all
//   counters at zero, and empties both registers. The state also returns to
//   that point after every final byte.
//   Values longer than 2^COUNT_BITS - 1 bytes are reported invalid.
// ----------------------------------------------------------------------------
module entity_tag_parser
    import etp_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic        weak_res,
    output logic        wildcard_res,
    output logic [15:0] tag_start,
    output logic [15:0] tag_length
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int EXT_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // input register
    logic                  s1_valid_reg;
    logic [7:0]            s1_byte_reg;
    logic                  s1_last_reg;
    logic                  s1_advance;

    // parser state
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [COUNT_BITS-1:0] quote_off_reg, quote_off_next;
    logic [COUNT_BITS-1:0] qlen_reg, qlen_next;
    logic                  weak_reg, weak_next;
    logic                  ovf_reg, ovf_next;

    // result register
    logic                  out_valid_reg;
    logic                  valid_res_reg, valid_res_next;
    logic                  weak_res_reg, weak_res_next;
    logic                  wild_res_reg, wild_res_next;
    logic [15:0]           tag_start_reg, tag_start_next;
    logic [15:0]           tag_len_reg, tag_len_next;

    logic [EXT_W-1:0]      start_ext;
    logic [EXT_W-1:0]      len_ext;
    logic                  res_ok, res_tag;

    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = PH_ERR;
        case (phase_reg)
            PH_LEAD:
            begin
                if (is_blank(s1_byte_reg))
                    phase_next = PH_LEAD;
                else if (s1_byte_reg == CH_STAR)
                    phase_next = PH_STAR;
                else if (s1_byte_reg == CH_W_UP || s1_byte_reg == CH_W_LO)
                    phase_next = PH_WPRE;
                else if (s1_byte_reg == CH_QUOTE)
                    phase_next = PH_INQ;
            end
            PH_STAR:
            begin
                if (is_blank(s1_byte_reg))
                    phase_next = PH_STAR;
            end
            PH_WPRE:
            begin
                if (s1_byte_reg == CH_SLASH)
                    phase_next = PH_WSP;
            end
            PH_WSP:
            begin
                if (is_blank(s1_byte_reg))
                    phase_next = PH_WSP;
                else if (s1_byte_reg == CH_QUOTE)
                    phase_next = PH_INQ;
            end
            PH_INQ:
            begin
                if (is_term(s1_byte_reg))
                    phase_next = PH_ERR;
                else if (s1_byte_reg == CH_BSLASH)
                    phase_next = PH_ESC;
                else if (s1_byte_reg == CH_QUOTE)
                    phase_next = PH_CLOSED;
                else
                    phase_next = PH_INQ;
            end
            PH_ESC:
            begin
                phase_next = is_term(s1_byte_reg) ? PH_ERR : PH_INQ;
            end
            PH_CLOSED:
            begin
                if (is_blank(s1_byte_reg))
                    phase_next = PH_CLOSED;
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase
    end

    // counters, flags and result
    always_comb
    begin
        ovf_next       = ovf_reg || (byte_pos_reg == COUNT_MAX);
        byte_pos_next  = (byte_pos_reg == COUNT_MAX) ? byte_pos_reg
                                                     : byte_pos_reg + COUNT_BITS'(1);
        quote_off_next = quote_off_reg;
        qlen_next      = qlen_reg;
        weak_next      = weak_reg;

        if ((phase_reg == PH_LEAD || phase_reg == PH_WSP) && s1_byte_reg == CH_QUOTE)
            quote_off_next = byte_pos_reg;
        if (phase_reg == PH_WPRE && s1_byte_reg == CH_SLASH)
            weak_next = 1'b1;
        if (phase_reg == PH_INQ && !is_term(s1_byte_reg) && s1_byte_reg == CH_QUOTE)
            qlen_next = byte_pos_reg - quote_off_reg + COUNT_BITS'(1);

        res_ok  = !ovf_next && (phase_next == PH_STAR || phase_next == PH_CLOSED);
        res_tag = res_ok && (phase_next == PH_CLOSED);

        start_ext = EXT_W'(quote_off_next);
        len_ext   = EXT_W'(qlen_next);

        valid_res_next = res_ok;
        wild_res_next  = res_ok && (phase_next == PH_STAR);
        weak_res_next  = res_tag && weak_next;
        tag_start_next = res_tag ? start_ext[15:0] : 16'd0;
        tag_len_next   = res_tag ? len_ext[15:0] : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            byte_pos_reg  <= '0;
            quote_off_reg <= '0;
            qlen_reg      <= '0;
            weak_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                phase_reg     <= PH_LEAD;
                byte_pos_reg  <= '0;
                quote_off_reg <= '0;
                qlen_reg      <= '0;
                weak_reg      <= 1'b0;
                ovf_reg       <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                byte_pos_reg  <= byte_pos_next;
                quote_off_reg <= quote_off_next;
                qlen_reg      <= qlen_next;
                weak_reg      <= weak_next;
                ovf_reg       <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            valid_res_reg <= valid_res_next;
            weak_res_reg  <= weak_res_next;
            wild_res_reg  <= wild_res_next;
            tag_start_reg <= tag_start_next;
            tag_len_reg   <= tag_len_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = valid_res_reg;
    assign weak_res     = weak_res_reg;
    assign wildcard_res = wild_res_reg;
    assign tag_start    = tag_start_reg;
    assign tag_length   = tag_len_reg;

    // an invalid result carries no other information
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !valid_res_reg) |->
            (!weak_res_reg && !wild_res_reg && tag_start_reg == 16'd0
             && tag_len_reg == 16'd0))
        else $error("invalid result with non-zero fields");

    // wildcard never carries a weak flag or a tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && wild_res_reg) |->
            (valid_res_reg && !weak_res_reg && tag_len_reg == 16'd0))
        else $error("wildcard result with tag fields");

    // state returns to the start after a final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=>
            (phase_reg == PH_LEAD && byte_pos_reg == '0 && !ovf_reg && !weak_reg))
        else $error("parser state not cleared after final byte");

    // overflow only once the position counter has saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (byte_pos_reg == COUNT_MAX))
        else $error("overflow flag without saturated position");

    // a final byte is only consumed when the result register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && s1_valid_reg && s1_last_reg) |-> !s1_advance)
        else $error("final byte consumed while result register is full");

endmodule

// File: tb/sv/etag_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etag_result_checker
// Watches both channels of entity_tag_parser. Every byte taken by the block
// is run through a local copy of the entity-tag parse, and each result word
// the block hands out is compared, field by field and in order, with the
// oldest predicted result.
// ----------------------------------------------------------------------------
module etag_result_checker
    import etp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        valid_res,
    input  logic        weak_res,
    input  logic        wildcard_res,
    input  logic [15:0] tag_start,
    input  logic [15:0] tag_length,
    output int          fail_cnt,
    output int          open_cnt,
    output int          result_cnt,
    output int          tag_cnt,
    output int          weak_cnt,
    output int          wild_cnt
);

    localparam logic [15:0] POS_TOP = 16'hFFFF;

    typedef struct packed {
        logic        ok;
        logic        weak_flag;
        logic        wild;
        logic [15:0] start;
        logic [15:0] len;
    } etag_t;

    etag_t       pending_tags[$];
    phase_t      cur_phase;
    logic [15:0] pos;
    logic [15:0] quote_pos;
    logic [15:0] tag_len;
    logic        weak_seen;
    logic        too_long;

    function automatic logic blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic breaks(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
    endfunction

    task automatic clear_parser();
        cur_phase = PH_LEAD;
        pos       = '0;
        quote_pos = '0;
        tag_len   = '0;
        weak_seen = 1'b0;
        too_long  = 1'b0;
    endtask

    task automatic parse_header_byte(input logic [7:0] c, input logic fin);
        phase_t nx;
        etag_t  r;
        logic   ok;
        nx = PH_ERR;
        if (pos == POS_TOP)
            too_long = 1'b1;
        case (cur_phase)
            PH_LEAD:
                if (blank(c))
                    nx = PH_LEAD;
                else if (c == CH_STAR)
                    nx = PH_STAR;
                else if (c == CH_W_UP || c == CH_W_LO)
                    nx = PH_WPRE;
                else if (c == CH_QUOTE)
                begin
                    nx        = PH_INQ;
                    quote_pos = pos;
                end
            PH_STAR:
                if (blank(c))
                    nx = PH_STAR;
            PH_WPRE:
                if (c == CH_SLASH)
                begin
                    nx        = PH_WSP;
                    weak_seen = 1'b1;
                end
            PH_WSP:
                if (blank(c))
                    nx = PH_WSP;
                else if (c == CH_QUOTE)
                begin
                    nx        = PH_INQ;
                    quote_pos = pos;
                end
            PH_INQ:
                if (breaks(c))
                    nx = PH_ERR;
                else if (c == CH_BSLASH)
                    nx = PH_ESC;
                else if (c == CH_QUOTE)
                begin
                    nx      = PH_CLOSED;
                    tag_len = pos - quote_pos + 16'd1;
                end
                else
                    nx = PH_INQ;
            PH_ESC:
                nx = breaks(c) ? PH_ERR : PH_INQ;
            PH_CLOSED:
                if (blank(c))
                    nx = PH_CLOSED;
            default:
                nx = PH_ERR;
        endcase
        cur_phase = nx;
        if (pos != POS_TOP)
            pos = pos + 16'd1;
        if (fin)
        begin
            ok          = !too_long && (cur_phase == PH_STAR || cur_phase == PH_CLOSED);
            r.ok        = ok;
            r.wild      = ok && (cur_phase == PH_STAR);
            r.weak_flag = ok && (cur_phase == PH_CLOSED) && weak_seen;
            r.start     = (ok && cur_phase == PH_CLOSED) ? quote_pos : 16'd0;
            r.len       = (ok && cur_phase == PH_CLOSED) ? tag_len : 16'd0;
            pending_tags.push_back(r);
            clear_parser();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        etag_t got;
        etag_t want;
        if (!rst_n)
        begin
            clear_parser();
            pending_tags.delete();
            fail_cnt   = 0;
            open_cnt   = 0;
            result_cnt = 0;
            tag_cnt    = 0;
            weak_cnt   = 0;
            wild_cnt   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {valid_res, weak_res, wildcard_res, tag_start, tag_length};
                result_cnt++;
                if (pending_tags.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: unexpected result word ok=%0b weak=%0b wild=%0b",
                                 $time, got.ok, got.weak_flag, got.wild);
                end
                else
                begin
                    want = pending_tags.pop_front();
                    if (got.ok !== want.ok || got.weak_flag !== want.weak_flag
                        || got.wild !== want.wild || got.start !== want.start
                        || got.len !== want.len)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"%0t: mismatch, expected ok=%0b weak=%0b wild=%0b ",
                                      "start=%0d len=%0d, got ok=%0b weak=%0b wild=%0b ",
                                      "start=%0d len=%0d"},
                                     $time, want.ok, want.weak_flag, want.wild, want.start,
                                     want.len, got.ok, got.weak_flag, got.wild, got.start,
                                     got.len);
                    end
                    if (want.ok && !want.wild)
                        tag_cnt++;
                    if (want.weak_flag)
                        weak_cnt++;
                    if (want.wild)
                        wild_cnt++;
                end
            end
            if (in_valid && in_ready)
                parse_header_byte(data_byte, last);
            open_cnt = pending_tags.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for entity_tag_parser: short hand-written header
// values for the edge cases, then random well-formed, broken and noise
// values, with bursty input and a stalling receiver. Checking is done by
// etag_result_checker.
// ----------------------------------------------------------------------------
module testbench;
    import etp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        valid_res;
    logic        weak_res;
    logic        wildcard_res;
    logic [15:0] tag_start;
    logic [15:0] tag_length;

    int          fail_cnt;
    int          open_cnt;
    int          result_cnt;
    int          tag_cnt;
    int          weak_cnt;
    int          wild_cnt;

    logic [7:0]  value_q[$];
    int          value_cnt = 0;
    int          byte_cnt = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    logic        ready_next = 1'b0;

    always #5 clk = ~clk;

    entity_tag_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valid_res    (valid_res),
        .weak_res     (weak_res),
        .wildcard_res (wildcard_res),
        .tag_start    (tag_start),
        .tag_length   (tag_length)
    );

    etag_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valid_res    (valid_res),
        .weak_res     (weak_res),
        .wildcard_res (wildcard_res),
        .tag_start    (tag_start),
        .tag_length   (tag_length),
        .fail_cnt     (fail_cnt),
        .open_cnt     (open_cnt),
        .result_cnt   (result_cnt),
        .tag_cnt      (tag_cnt),
        .weak_cnt     (weak_cnt),
        .wild_cnt     (wild_cnt)
    );

    // receiver: long ready runs, short and long stalls
    always @(negedge clk)
    begin
        if (hold_left == 0)
        begin
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    ready_next = 1'b1;
                    hold_left  = $urandom_range(1, 40);
                end
                2:
                begin
                    ready_next = 1'b0;
                    hold_left  = $urandom_range(1, 4);
                end
                default:
                begin
                    ready_next = 1'b0;
                    hold_left  = $urandom_range(5, 25);
                end
            endcase
        end
        else
            hold_left--;
        out_ready <= ready_next;
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BSLASH || b == CH_CR || b == CH_LF || b == CH_NUL);
        return b;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            value_q.push_back(s[i]);
    endtask

    task automatic push_blanks(input int n);
        repeat (n)
            value_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 5);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        byte_cnt++;
    endtask

    task automatic send_value();
        for (int i = 0; i < value_q.size(); i++)
            send_byte(value_q[i], i == value_q.size() - 1);
        value_cnt++;
    endtask

    task automatic send_text(input string s);
        value_q.delete();
        push_text(s);
        send_value();
    endtask

    task automatic build_tag();
        int         n;
        logic [7:0] e;
        push_blanks($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0)
        begin
            value_q.push_back($urandom_range(0, 1) ? CH_W_UP : CH_W_LO);
            value_q.push_back(CH_SLASH);
            push_blanks($urandom_range(0, 2));
        end
        value_q.push_back(CH_QUOTE);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
        repeat (n)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                do
                    e = 8'($urandom_range(0, 255));
                while (e == CH_CR || e == CH_LF || e == CH_NUL);
                value_q.push_back(CH_BSLASH);
                value_q.push_back(e);
            end
            else
                value_q.push_back(plain_byte());
        end
        value_q.push_back(CH_QUOTE);
        push_blanks($urandom_range(0, 3));
    endtask

    initial
    begin
        int         rand_start;
        int         pick;
        logic [7:0] ctl;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("*");
        send_text(" \t*\t ");
        send_text("**");
        send_text("*\"a\"");
        send_text("\"\"");
        send_text("\"abc\"");
        send_text("W/\"x\"");
        send_text("w/ \t\"y\" ");
        send_text("W/");
        send_text("W\"a\"");
        send_text(" \t");
        send_text("\"");
        send_text("\"a\\\"b\"");
        send_text("\"ab\\\"");
        send_text("\"a\" x");
        send_text("\"a\"\"");
        send_text("\"\\\\\"");
        value_q.delete();
        push_text("\"a");
        value_q.push_back(CH_CR);
        push_text("\"");
        send_value();
        value_q.delete();
        push_text("\"a\\");
        value_q.push_back(CH_LF);
        push_text("\"");
        send_value();
        value_q.delete();
        push_text("\"a\"");
        value_q.push_back(CH_NUL);
        send_value();
        value_q.delete();
        value_q.push_back(CH_QUOTE);
        value_q.push_back(8'hFF);
        value_q.push_back(8'h80);
        value_q.push_back(8'h7F);
        value_q.push_back(CH_QUOTE);
        send_value();

        rand_start = byte_cnt;
        while (byte_cnt - rand_start < 1950)
        begin
            value_q.delete();
            pick = $urandom_range(0, 99);
            if (pick < 55)
                build_tag();
            else if (pick < 65)
            begin
                push_blanks($urandom_range(0, 3));
                value_q.push_back(CH_STAR);
                push_blanks($urandom_range(0, 3));
            end
            else if (pick < 85)
            begin
                build_tag();
                case ($urandom_range(0, 4))
                    0:
                        value_q[$urandom_range(0, value_q.size() - 1)] =
                            8'($urandom_range(0, 255));
                    1:
                    begin
                        ctl = ($urandom_range(0, 2) == 0) ? CH_NUL
                            : ($urandom_range(0, 1) ? CH_CR : CH_LF);
                        value_q.insert($urandom_range(0, value_q.size()), ctl);
                    end
                    2:
                        if (value_q.size() > 1)
                            value_q.delete($urandom_range(0, value_q.size() - 1));
                    3:
                        if (value_q.size() > 1)
                            void'(value_q.pop_back());
                    default:
                        value_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            else
                repeat ($urandom_range(1, 8))
                    value_q.push_back(8'($urandom_range(0, 255)));
            send_value();
        end
        in_valid <= 1'b0;

        while (open_cnt != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d header values in %0d bytes, hand-written edge cases first.",
                 value_cnt, byte_cnt);
        $display("Checked %0d results: %0d tags (%0d weak), %0d wildcards, %0d failures.",
                 result_cnt, tag_cnt, weak_cnt, wild_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("entity_tag_parser test passed");
        else
            $display("entity_tag_parser test failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", open_cnt);
        $display("entity_tag_parser test failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/etp_pkg.sv
hw/rtl/entity_tag_parser.sv
tb/sv/etag_result_checker.sv
tb/sv/testbench.sv
